FILE: hdl/gmf_pkg.sv
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared widths, types and codes of the 3x3 median grid filter.
// ----------------------------------------------------------------------------
package gmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 8;
  localparam int MED_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int WIN_N    = 9;
  localparam int CNT_W    = 4;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [CFG_DAT_W-1:0] DIM_RESET = 8'd100;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]    med_t;
  typedef logic [COORD_W-1:0]         coord_t;

  typedef struct packed {
    logic    clear;
    logic    insert;
    sample_t key;
  } sort_ctl_t;

endpackage

FILE: hdl/gmf_in_if.sv
// ----------------------------------------------------------------------------
// gmf_in_if / gmf_out_if / gmf_cfg_if
// Valid/ready channels of the median grid filter.
// ----------------------------------------------------------------------------
interface gmf_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  gmf_pkg::coord_t   row_number;
  gmf_pkg::coord_t   col_number;
  gmf_pkg::sample_t  sample;
  modport source (output valid, operation, row_number, col_number, sample, input ready);
  modport sink   (input valid, operation, row_number, col_number, sample, output ready);
endinterface

interface gmf_out_if;
  logic              valid;
  logic              ready;
  gmf_pkg::coord_t   out_row;
  gmf_pkg::coord_t   out_col;
  gmf_pkg::med_t     median_x2;
  logic              status;
  modport source (output valid, out_row, out_col, median_x2, status, input ready);
  modport sink   (input valid, out_row, out_col, median_x2, status, output ready);
endinterface

interface gmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gmf_pkg::CFG_IDX_W-1:0]    index;
  logic [gmf_pkg::CFG_DAT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/gmf_grid_mem.sv
// ----------------------------------------------------------------------------
// gmf_grid_mem
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gmf_grid_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  gmf_pkg::sample_t  wdata,
  input  logic [AW-1:0]     raddr,
  output gmf_pkg::sample_t  rdata
);
  import gmf_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/gmf_sorter.sv
// ----------------------------------------------------------------------------
// gmf_sorter
// Insertion sorter for up to nine samples and median selection.
// ----------------------------------------------------------------------------
module gmf_sorter (
  input  logic                clk,
  input  logic                rst,
  input  gmf_pkg::sort_ctl_t  ctl,
  output gmf_pkg::med_t       median_x2
);
  import gmf_pkg::*;

  sample_t          vals [WIN_N];
  sample_t          vals_next [WIN_N];
  logic [CNT_W-1:0] n;
  logic [WIN_N-1:0] gt;
  med_t             mid_lo;
  med_t             mid_hi;

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      gt[i] = (CNT_W'(i) >= n) || (vals[i] > ctl.key);
    end
    for (int i = 0; i < WIN_N; i++) begin
      if (!gt[i]) begin
        vals_next[i] = vals[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        vals_next[i] = vals[(i > 0) ? i - 1 : 0];
      end else begin
        vals_next[i] = ctl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      n <= '0;
    end else if (ctl.insert) begin
      n <= n + CNT_W'(1);
    end
    if (ctl.insert) begin
      vals <= vals_next;
    end
  end

  always_comb begin
    mid_lo = '0;
    mid_hi = '0;
    case (n)
      4'd1: begin mid_lo = MED_W'(vals[0]); mid_hi = MED_W'(vals[0]); end
      4'd2: begin mid_lo = MED_W'(vals[0]); mid_hi = MED_W'(vals[1]); end
      4'd3: begin mid_lo = MED_W'(vals[1]); mid_hi = MED_W'(vals[1]); end
      4'd4: begin mid_lo = MED_W'(vals[1]); mid_hi = MED_W'(vals[2]); end
      4'd5: begin mid_lo = MED_W'(vals[2]); mid_hi = MED_W'(vals[2]); end
      4'd6: begin mid_lo = MED_W'(vals[2]); mid_hi = MED_W'(vals[3]); end
      4'd7: begin mid_lo = MED_W'(vals[3]); mid_hi = MED_W'(vals[3]); end
      4'd8: begin mid_lo = MED_W'(vals[3]); mid_hi = MED_W'(vals[4]); end
      4'd9: begin mid_lo = MED_W'(vals[4]); mid_hi = MED_W'(vals[4]); end
      default: begin mid_lo = '0; mid_hi = '0; end
    endcase
    median_x2 = mid_lo + mid_hi;
  end

endmodule

FILE: hdl/grid_median3x3_filter_top.sv
// ----------------------------------------------------------------------------
// grid_median3x3_filter_top
// 3x3 median filter over a grid of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Input transfers carry a store or a query for a 1-based cell. A store is
// written into the grid in the cycle of its transfer and leaves the input
// ready, so stores run at one per cycle. A query walks its nine neighbors
// through the single read port of the grid memory, one per cycle, feeding an
// insertion sorter. Input ready stays low until the query's result is
// loaded into the output register; a query outside the grid in use skips
// the walk and returns status 1. No new item is taken during a query.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is taken, and only a second finished query waits.
// The configuration channel is always ready.
// After reset the block clears the grid, one entry per cycle, all
// MAX_DIM*MAX_DIM entries (16384 by default), with input ready low.
// ----------------------------------------------------------------------------
module grid_median3x3_filter_top #(
  parameter int MAX_DIM = 128
) (
  input  logic      clk,
  input  logic      rst,
  gmf_in_if.sink    in_ch,
  gmf_out_if.source out_ch,
  gmf_cfg_if.sink   cfg_ch
);
  import gmf_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = ((DW > COORD_W + 1) ? DW : COORD_W + 1) + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state;
  logic [AW:0]          clr_cnt;
  logic [CFG_DAT_W-1:0] rows_reg;
  logic [CFG_DAT_W-1:0] cols_reg;
  logic [CW-1:0]        nr;
  logic [CW-1:0]        nc;
  coord_t               q_row;
  coord_t               q_col;
  logic                 q_bad;
  logic [1:0]           dr;
  logic [1:0]           dc;
  logic                 rd_vld;
  logic [CW-1:0]        rr;
  logic [CW-1:0]        cc;
  logic                 nb_ok;
  logic                 in_inside;
  logic                 in_acc;
  logic                 we;
  logic [AW-1:0]        waddr;
  sample_t              wdata;
  logic [AW-1:0]        raddr;
  sample_t              rdata;
  sort_ctl_t            sctl;
  med_t                 med;

  always_comb begin
    nr = (32'(rows_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(rows_reg);
    nc = (32'(cols_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(cols_reg);
    in_inside = (in_ch.row_number != '0) && (CW'(in_ch.row_number) <= nr)
             && (in_ch.col_number != '0) && (CW'(in_ch.col_number) <= nc);
    rr = CW'(q_row) + CW'(dr);
    cc = CW'(q_col) + CW'(dc);
    nb_ok = (rr >= CW'(2)) && (rr <= nr + CW'(1)) && (cc >= CW'(2)) && (cc <= nc + CW'(1));
    raddr = AW'((32'(rr) - 32'd2) * MAX_DIM + 32'(cc) - 32'd2);
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt[AW-1:0];
      wdata = '0;
    end else begin
      we    = in_acc && (in_ch.operation == OP_STORE) && in_inside;
      waddr = AW'((32'(in_ch.row_number) - 32'd1) * MAX_DIM + 32'(in_ch.col_number) - 32'd1);
      wdata = in_ch.sample;
    end
  end

  gmf_grid_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sctl.clear  = in_acc;
    sctl.insert = rd_vld;
    sctl.key    = rdata;
  end

  gmf_sorter u_sort (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .median_x2 (med)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      rows_reg <= DIM_RESET;
      cols_reg <= DIM_RESET;
      rd_vld   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_ROWS) begin
          rows_reg <= cfg_ch.data;
        end else if (cfg_ch.index == REG_COLS) begin
          cols_reg <= cfg_ch.data;
        end
      end
      if (out_ch.valid && out_ch.ready && state != ST_DONE) begin
        out_ch.valid <= 1'b0;
      end
      rd_vld <= (state == ST_READ) && nb_ok;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + (AW + 1)'(1);
          if (clr_cnt == (AW + 1)'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_ch.operation == OP_QUERY) begin
            q_row <= in_ch.row_number;
            q_col <= in_ch.col_number;
            q_bad <= !in_inside;
            dr    <= '0;
            dc    <= '0;
            state <= in_inside ? ST_READ : ST_DONE;
          end
        end
        ST_READ: begin
          if (dc == 2'd2) begin
            dc <= '0;
            dr <= dr + 2'd1;
            if (dr == 2'd2) begin
              state <= ST_DRAIN;
            end
          end else begin
            dc <= dc + 2'd1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid     <= 1'b1;
            out_ch.out_row   <= q_row;
            out_ch.out_col   <= q_col;
            out_ch.median_x2 <= q_bad ? '0 : med;
            out_ch.status    <= q_bad ? STATUS_OUTSIDE : STATUS_OK;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/gmf_checker.sv
// ----------------------------------------------------------------------------
// gmf_checker
// Port-level checks of the median grid filter, bound to its top level.
// ----------------------------------------------------------------------------
module gmf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_op,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_status,
  input gmf_pkg::med_t        out_median
);
  import gmf_pkg::*;

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STATUS_OUTSIDE |-> out_median == '0)
    else $error("outside query with nonzero median");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("input ready during a query");

endmodule

bind grid_median3x3_filter_top gmf_checker u_gmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.operation),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_median (out_ch.median_x2)
);
